// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. The enclosing module must provide
// clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Format codes, character constants, cell control type and digit-to-ASCII map.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam logic [1:0] FMT_SDEC = 2'd0;
    localparam logic [1:0] FMT_UDEC = 2'd1;
    localparam logic [1:0] FMT_LHEX = 2'd2;
    localparam logic [1:0] FMT_UHEX = 2'd3;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic clear;   // zero the digit
        logic conv;    // take one bit from below (double dabble step)
        logic dec;     // apply the add-3 correction (decimal)
        logic shift;   // take the whole digit from the cell below
    } cell_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < DIGIT_TEN)
            return CHAR_ZERO + {4'b0000, d};
        else
            return base + {4'b0000, d} - {4'b0000, DIGIT_TEN};
    endfunction

endpackage

// ===== src/itoa_cell.sv =====
// ----------------------------------------------------------------------------
// itoa_cell
// One 4-bit digit of the conversion chain: a shift-and-add-3 step in convert
// mode, or a plain digit move toward the top in emit mode.
// ----------------------------------------------------------------------------
module itoa_cell
(
    input  logic                   clk,
    input  itoa_pkg::cell_ctrl_t   ctrl,
    input  logic                   bit_in,
    output logic                   bit_out,
    input  logic [3:0]             digit_in,
    output logic [3:0]             digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb
    begin
        adj = digit_reg;
        if (ctrl.dec && (digit_reg >= 4'd5))
            adj = digit_reg + 4'd3;
    end

    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
            digit_next = 4'd0;
        else if (ctrl.conv)
            digit_next = {adj[2:0], bit_in};
        else if (ctrl.shift)
            digit_next = digit_in;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== src/integer_to_ascii_converter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_converter: binary word to ASCII decimal or hex text.
// An accepted word is shifted through the digit chain bit by bit, then a '-'
// goes out if it is negative, then the digit slots (10 at width 32) go out
// from the top, leading zeros skipped; there are no stalls.
// Reset (rst_n, async) returns to idle and drops valid; digit cells unreset.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  valid,
    output logic [7:0]            char_code,
    output logic                  last
);

`include "assert_macros.svh"

    localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] bin_reg, bin_next;
    logic                  neg_reg, neg_next;
    logic                  hex_reg, hex_next;
    logic                  upper_reg, upper_next;
    logic                  started_reg, started_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    itoa_pkg::cell_ctrl_t  ctrl;
    logic                  carry [NUM_DIGITS+1];
    logic [3:0]            digits [NUM_DIGITS];
    logic [3:0]            top_digit;
    logic                  accept;
    logic                  in_neg;

    assign accept    = start && (state_reg == ST_IDLE);
    assign in_neg    = (req_type == itoa_pkg::FMT_SDEC) && value[DATA_WIDTH-1];
    assign top_digit = digits[NUM_DIGITS-1];
    assign carry[0]  = bin_reg[DATA_WIDTH-1];

    always_comb
    begin
        ctrl.clear = accept;
        ctrl.conv  = (state_reg == ST_CONV);
        ctrl.dec   = (state_reg == ST_CONV) && !hex_reg;
        ctrl.shift = (state_reg == ST_EMIT);
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            logic [3:0] below;
            if (gi == 0)
            begin : g_bottom
                assign below = 4'd0;
            end
            else
            begin : g_mid
                assign below = digits[gi-1];
            end
            itoa_cell u_cell
            (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (carry[gi]),
                .bit_out  (carry[gi+1]),
                .digit_in (below),
                .digit    (digits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bin_next     = bin_reg;
        neg_next     = neg_reg;
        hex_next     = hex_reg;
        upper_next   = upper_reg;
        started_next = started_reg;
        valid_next   = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bin_next     = in_neg ? (~value + 1'b1) : value;
                    neg_next     = in_neg;
                    hex_next     = req_type[1];
                    upper_next   = (req_type == itoa_pkg::FMT_UHEX);
                    started_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bin_next = {bin_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
                begin
                    cnt_next   = CNT_W'(NUM_DIGITS - 1);
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                valid_next = 1'b1;
                char_next  = itoa_pkg::CHAR_MINUS;
                last_next  = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // skip leading zeros, but the final slot always goes out
                if (started_reg || (top_digit != 4'd0) || (cnt_reg == '0))
                begin
                    valid_next = 1'b1;
                    char_next  = itoa_pkg::digit_char(top_digit, upper_reg);
                    last_next  = (cnt_reg == '0);
                end
                started_next = started_reg || (top_digit != 4'd0);
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        bin_reg     <= bin_next;
        neg_reg     <= neg_next;
        hex_reg     <= hex_next;
        upper_reg   <= upper_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    `ASSERT_SAME(a_chain_no_overflow, state_reg == ST_CONV, !carry[NUM_DIGITS],
        "digit chain overflowed")
    `ASSERT_NEXT(a_gap_after_last, valid && last, !valid,
        "word emitted right after final character")
    `ASSERT_SAME(a_done_on_last, $fell(busy), valid && last,
        "went idle without final character")
    `ASSERT_SAME(a_minus_not_last, valid && (char_code == itoa_pkg::CHAR_MINUS), !last,
        "minus sign marked as final character")

endmodule

// ===== tb/sv/tb_integer_to_ascii_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_converter
// Self-checking bench for the integer to ASCII converter. Words go in through
// the start/busy command port in all four formats, and the predicted character
// text is compared with every strobed character, last flag included.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_converter;

    typedef struct {
        logic [1:0]  fmt;
        logic [31:0] word;
        int unsigned gap;
    } conv_word_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] value;
    logic        valid;
    logic [7:0]  char_code;
    logic        last;

    conv_word_t  pending_words[$];
    text_char_t  expected_text[$];
    logic        word_taken;
    int unsigned holdoff_cnt;
    int unsigned errors;
    int unsigned words_taken;
    int unsigned chars_checked;
    int unsigned fmt_seen[4];

    integer_to_ascii_converter #(.DATA_WIDTH(32)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .valid     (valid),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Builds the expected text of one word and appends it, most significant first
    function automatic void queue_text(input logic [1:0] fmt, input logic [31:0] word);
        logic [31:0] mag;
        logic [31:0] rem;
        logic [7:0]  letter_base;
        logic [7:0]  chars[$];
        logic        neg;
        text_char_t  tc;
        neg = (fmt == itoa_pkg::FMT_SDEC) && word[31];
        mag = neg ? (~word + 32'd1) : word;
        letter_base = (fmt == itoa_pkg::FMT_UHEX) ? itoa_pkg::CHAR_UPPER_A
                                                  : itoa_pkg::CHAR_LOWER_A;
        if (mag == 32'd0)
        begin
            chars.push_front(itoa_pkg::CHAR_ZERO);
        end
        while (mag != 32'd0)
        begin
            if (fmt == itoa_pkg::FMT_SDEC || fmt == itoa_pkg::FMT_UDEC)
            begin
                rem = mag % 32'd10;
                mag = mag / 32'd10;
            end
            else
            begin
                rem = {28'd0, mag[3:0]};
                mag = mag >> 4;
            end
            if (rem < 32'd10)
                chars.push_front(itoa_pkg::CHAR_ZERO + {4'd0, rem[3:0]});
            else
                chars.push_front(letter_base + {4'd0, rem[3:0]} - 8'd10);
        end
        if (neg)
        begin
            chars.push_front(itoa_pkg::CHAR_MINUS);
        end
        foreach (chars[i])
        begin
            tc.code = chars[i];
            tc.last = (i == chars.size() - 1);
            expected_text.push_back(tc);
        end
    endfunction

    function automatic void add_word(input logic [1:0] fmt, input logic [31:0] word,
                                     input int unsigned gap);
        conv_word_t w;
        w.fmt  = fmt;
        w.word = word;
        w.gap  = gap;
        pending_words.push_back(w);
    endfunction

    // Driver: holds a word until it is taken, then idles for the next word's gap
    always @(negedge clk)
    begin
        conv_word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !word_taken))
        begin
            if (pending_words.size() != 0 && holdoff_cnt >= pending_words[0].gap)
            begin
                w = pending_words.pop_front();
                holdoff_cnt = 0;
                start    <= 1'b1;
                req_type <= w.fmt;
                value    <= w.word;
            end
            else
            begin
                if (pending_words.size() != 0)
                    holdoff_cnt = holdoff_cnt + 1;
                // noise on the payload while start is low
                start    <= 1'b0;
                req_type <= 2'($urandom_range(0, 3));
                value    <= $urandom;
            end
        end
    end

    // Monitor: checks strobed characters, records accepted words
    always @(posedge clk)
    begin
        text_char_t exp_char;
        word_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (valid === 1'b1)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character 0x%02h last=%0b", char_code, last);
                    errors = errors + 1;
                end
                else
                begin
                    exp_char = expected_text.pop_front();
                    chars_checked = chars_checked + 1;
                    if (char_code !== exp_char.code)
                    begin
                        $error("char_code: expected 0x%02h, got 0x%02h",
                               exp_char.code, char_code);
                        errors = errors + 1;
                    end
                    if (last !== exp_char.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_char.last, last);
                        errors = errors + 1;
                    end
                end
            end
            else if (valid !== 1'b0)
            begin
                $error("valid: expected 0 or 1, got %b", valid);
                errors = errors + 1;
            end
            if (start && busy === 1'b0)
            begin
                queue_text(req_type, value);
                words_taken = words_taken + 1;
                fmt_seen[req_type] = fmt_seen[req_type] + 1;
            end
        end
    end

    initial
    begin
        logic [31:0] corner_words[6];
        logic [31:0] w;
        logic [1:0]  fmt;
        int unsigned idle_on;
        int unsigned settle;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = itoa_pkg::FMT_SDEC;
        value       = 32'd0;
        word_taken  = 1'b0;
        holdoff_cnt = 0;
        errors      = 0;
        words_taken = 0;
        chars_checked = 0;
        foreach (fmt_seen[i])
            fmt_seen[i] = 0;

        // zero, most negative, most positive, all ones, ten and hex letters
        corner_words[0] = 32'h0000_0000;
        corner_words[1] = 32'h8000_0000;
        corner_words[2] = 32'h7FFF_FFFF;
        corner_words[3] = 32'hFFFF_FFFF;
        corner_words[4] = 32'h0000_000A;
        corner_words[5] = 32'hABCD_EF19;
        foreach (corner_words[i])
        begin
            add_word(itoa_pkg::FMT_SDEC, corner_words[i],
                     (i % 2) ? $urandom_range(0, 18) : 0);
            add_word(itoa_pkg::FMT_UDEC, corner_words[i],
                     (i % 2) ? 0 : $urandom_range(0, 18));
            add_word(itoa_pkg::FMT_LHEX, corner_words[i], $urandom_range(0, 18));
            add_word(itoa_pkg::FMT_UHEX, corner_words[i], 0);
        end

        // random words, in runs with and without idle gaps
        for (int blk = 0; blk < 8; blk++)
        begin
            idle_on = $urandom_range(0, 1);
            for (int n = 0; n < 10; n++)
            begin
                fmt = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 5))
                    0: w = $urandom_range(0, 99);
                    1: w = 32'd1 << $urandom_range(0, 31);
                    2: w = -($urandom_range(1, 1000));
                    3: w = (32'd1 << $urandom_range(0, 31)) - 32'd1;
                    default: w = $urandom;
                endcase
                add_word(fmt, w, idle_on ? $urandom_range(0, 18) : 0);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_words.size() != 0 || start);

        settle = 0;
        while (expected_text.size() != 0 && settle < 200)
        begin
            @(posedge clk);
            settle = settle + 1;
        end
        // catch stray characters after the last word
        repeat (64) @(posedge clk);

        if (expected_text.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_text.size());
            errors = errors + 1;
        end

        $display("converted %0d words (signed dec %0d, unsigned dec %0d, hex %0d/%0d)",
                 words_taken, fmt_seen[itoa_pkg::FMT_SDEC], fmt_seen[itoa_pkg::FMT_UDEC],
                 fmt_seen[itoa_pkg::FMT_LHEX], fmt_seen[itoa_pkg::FMT_UHEX]);
        $display("checked %0d characters, %0d errors", chars_checked, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
